@@ hw/rtl/pcd_pkg.sv @@
// Package for the percent decoder: character constants, status codes,
// escape phase type, result record and the hex digit helper.
// No dependencies.
package pcd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_DIGIT  = 2'd1,
        ST_INCOMPLETE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_OUTSIDE = 2'd0,
        PH_HIGH    = 2'd1,
        PH_LOW     = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       out_last;
    } result_t;

    typedef struct packed {
        logic       legal;
        logic [3:0] value;
    } nibble_t;

    function automatic nibble_t nibble_of(input logic [7:0] ch);
        nibble_t n;
        n.legal = 1'b0;
        n.value = 4'd0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            n.legal = 1'b1;
            n.value = 4'(ch - CH_ZERO);
        end
        else if (ch >= CH_LOW_A && ch <= CH_LOW_F)
        begin
            n.legal = 1'b1;
            n.value = 4'(ch - CH_LOW_A + 8'd10);
        end
        return n;
    endfunction

endpackage

@@ hw/rtl/percent_decoder_unit.sv @@
// Top level of the URL percent decoder.
// Depends on pcd_pkg, pcd_decode and pcd_out_buf.
//
// The encoded string enters one byte per item on the slave stream, with
// s_tlast on the final byte of each string. Each item gives zero or one
// result on the master stream: a decoded byte with status OK, an illegal
// hex digit error, or an incomplete escape error. m_tlast marks the final
// result of each string. After an illegal digit the rest of the string is
// dropped without results.
// A result is registered in the output buffer when its item is accepted.
// Throughput is one item per cycle while the buffer has room, as the escape
// state is updated on every accepted item.
// Reset clears the escape state and empties the result buffer.
// When the receiver stalls, results collect in a two-entry buffer; the
// slave side stays ready until both entries are full.
module percent_decoder_unit
    import pcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [1:0] m_tuser,   // status
    output logic       m_tlast    // out_last
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    can_push;

    assign s_tready = can_push;
    assign in_fire  = s_tvalid && can_push;

    pcd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    pcd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire && res_valid),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.out_last;

endmodule

@@ hw/rtl/pcd_decode.sv @@
// Escape state machine of the percent decoder and the decode logic for one item.
// Depends on pcd_pkg.
module pcd_decode
    import pcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [3:0] high_reg, high_next;
    logic       discard_reg, discard_next;
    nibble_t    nib;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_OUTSIDE;
            high_reg    <= 4'd0;
            discard_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            high_reg    <= high_next;
            discard_reg <= discard_next;
        end
    end

    always_comb
    begin
        nib          = nibble_of(in_byte);
        phase_next   = phase_reg;
        high_next    = high_reg;
        discard_next = discard_reg;
        res_valid    = 1'b0;
        res.out_byte = 8'd0;
        res.status   = ST_OK;
        res.out_last = in_last;
        if (discard_reg)
        begin
            if (in_last)
            begin
                discard_next = 1'b0;
                phase_next   = PH_OUTSIDE;
            end
        end
        else
        begin
            case (phase_reg)
                PH_HIGH, PH_LOW:
                begin
                    if (!nib.legal)
                    begin
                        phase_next   = PH_OUTSIDE;
                        discard_next = !in_last;
                        res_valid    = 1'b1;
                        res.status   = ST_BAD_DIGIT;
                        res.out_last = 1'b1;
                    end
                    else if (phase_reg == PH_HIGH)
                    begin
                        high_next = nib.value;
                        if (in_last)
                        begin
                            phase_next   = PH_OUTSIDE;
                            res_valid    = 1'b1;
                            res.status   = ST_INCOMPLETE;
                            res.out_last = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_LOW;
                        end
                    end
                    else
                    begin
                        phase_next   = PH_OUTSIDE;
                        res_valid    = 1'b1;
                        res.out_byte = {high_reg, nib.value};
                    end
                end
                default:
                begin
                    phase_next = PH_OUTSIDE;
                    if (in_byte == CH_PERCENT)
                    begin
                        if (in_last)
                        begin
                            res_valid    = 1'b1;
                            res.status   = ST_INCOMPLETE;
                            res.out_last = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HIGH;
                        end
                    end
                    else
                    begin
                        res_valid    = 1'b1;
                        res.out_byte = in_byte;
                    end
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/pcd_out_buf.sv @@
// Two-entry result buffer: an output register backed by a skid register.
// Depends on pcd_pkg.
module pcd_out_buf
    import pcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    can_push,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= push;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

@@ tb/percent_decoder_unit_tb.sv @@
// Self-checking testbench for percent_decoder_unit: directed strings, then random
// well-formed, broken and noisy strings, with random stalls on both streams.
// Depends on pcd_pkg and the percent_decoder_unit RTL.
module percent_decoder_unit_tb
    import pcd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic       has_res;
        logic [7:0] exp_byte;
        logic [1:0] exp_status;
        logic       exp_last;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam int RANDOM_ITEMS = 1750;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    phase_t     esc_phase = PH_OUTSIDE;
    logic [3:0] hi_nib = 4'd0;
    bit         skip_rest = 1'b0;

    result_t    pending_results[$];
    bit         failed = 1'b0;
    bit         quiet = 1'b0;
    int         decoded_items = 0;

    // The typed rows hold results that follow directly from the string itself.
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        {8'h41,      1'b0, 1'b1, 1'b1, 8'h41, ST_OK,         1'b0},
        {8'h00,      1'b0, 1'b1, 1'b1, 8'h00, ST_OK,         1'b0},
        {8'hff,      1'b1, 1'b1, 1'b1, 8'hff, ST_OK,         1'b1},
        {CH_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00, ST_OK,         1'b0},
        {CH_ZERO,    1'b0, 1'b1, 1'b0, 8'h00, ST_OK,         1'b0},
        {CH_ZERO,    1'b0, 1'b1, 1'b1, 8'h00, ST_OK,         1'b0},
        {CH_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00, ST_OK,         1'b0},
        {CH_LOW_F,   1'b0, 1'b1, 1'b0, 8'h00, ST_OK,         1'b0},
        {CH_LOW_F,   1'b0, 1'b1, 1'b1, 8'hff, ST_OK,         1'b0},
        {CH_PERCENT, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK,         1'b0},
        {CH_LOW_A,   1'b0, 1'b0, 1'b0, 8'h00, ST_OK,         1'b0},
        {CH_NINE,    1'b1, 1'b0, 1'b0, 8'h00, ST_OK,         1'b0},
        {CH_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00, ST_OK,         1'b0},
        {8'h67,      1'b0, 1'b1, 1'b1, 8'h00, ST_BAD_DIGIT,  1'b1},
        {8'h78,      1'b0, 1'b1, 1'b0, 8'h00, ST_OK,         1'b0},
        {CH_PERCENT, 1'b1, 1'b1, 1'b0, 8'h00, ST_OK,         1'b0},
        {CH_PERCENT, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK,         1'b0},
        {8'h46,      1'b1, 1'b1, 1'b1, 8'h00, ST_BAD_DIGIT,  1'b1},
        {CH_PERCENT, 1'b1, 1'b1, 1'b1, 8'h00, ST_INCOMPLETE, 1'b1},
        {CH_PERCENT, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK,         1'b0},
        {8'h35,      1'b1, 1'b1, 1'b1, 8'h00, ST_INCOMPLETE, 1'b1},
        {CH_PERCENT, 1'b0, 1'b0, 1'b0, 8'h00, ST_OK,         1'b0},
        {8'h3a,      1'b0, 1'b1, 1'b1, 8'h00, ST_BAD_DIGIT,  1'b1},
        {8'h60,      1'b1, 1'b1, 1'b0, 8'h00, ST_OK,         1'b0}
    };

    percent_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit hex_value(input logic [7:0] ch, output logic [3:0] val);
        val = 4'd0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            val = ch[3:0];
            return 1'b1;
        end
        if (ch >= CH_LOW_A && ch <= CH_LOW_F)
        begin
            val = ch[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void percent_decode_step(input logic [7:0] ch, input logic last,
                                                output bit produced, output result_t res);
        logic [3:0] nib;
        bit         legal;
        produced = 1'b0;
        res = '0;
        if (skip_rest)
        begin
            if (last)
            begin
                skip_rest = 1'b0;
                esc_phase = PH_OUTSIDE;
            end
            return;
        end
        if (esc_phase == PH_HIGH || esc_phase == PH_LOW)
        begin
            legal = hex_value(ch, nib);
            produced = 1'b1;
            if (!legal)
            begin
                esc_phase = PH_OUTSIDE;
                skip_rest = !last;
                res.status = ST_BAD_DIGIT;
                res.out_last = 1'b1;
            end
            else if (esc_phase == PH_HIGH)
            begin
                hi_nib = nib;
                if (last)
                begin
                    esc_phase = PH_OUTSIDE;
                    res.status = ST_INCOMPLETE;
                    res.out_last = 1'b1;
                end
                else
                begin
                    esc_phase = PH_LOW;
                    produced = 1'b0;
                end
            end
            else
            begin
                esc_phase = PH_OUTSIDE;
                res.out_byte = {hi_nib, nib};
                res.out_last = last;
            end
        end
        else if (ch == CH_PERCENT)
        begin
            if (last)
            begin
                produced = 1'b1;
                res.status = ST_INCOMPLETE;
                res.out_last = 1'b1;
            end
            else
            begin
                esc_phase = PH_HIGH;
            end
        end
        else
        begin
            esc_phase = PH_OUTSIDE;
            produced = 1'b1;
            res.out_byte = ch;
            res.out_last = last;
        end
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic last, input bit typed,
                             input bit typed_has, input result_t typed_res);
        bit      produced;
        bit      was_skipping;
        result_t res;
        while (!quiet && $urandom_range(0, 99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        was_skipping = skip_rest;
        percent_decode_step(ch, last, produced, res);
        if (typed)
        begin
            produced = typed_has;
            res = typed_res;
        end
        if (produced)
            pending_results.push_back(res);
        if (!was_skipping)
            decoded_items++;
    endtask

    function automatic logic [7:0] legal_digit();
        int r;
        r = $urandom_range(0, 15);
        if (r < 10)
            return CH_ZERO + 8'(r);
        return CH_LOW_A + 8'(r - 10);
    endfunction

    function automatic logic [7:0] odd_byte();
        case ($urandom_range(0, 7))
            0: return 8'h3a;
            1: return 8'h60;
            2: return 8'h67;
            3: return 8'h2f;
            4: return 8'h41 + 8'($urandom_range(0, 5));
            5: return CH_PERCENT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_string();
        logic [7:0] bytes[$];
        logic [7:0] b;
        int         kind;
        int         n;
        int         pos;
        kind = $urandom_range(0, 9);
        if (kind <= 8)
        begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 40)
                begin
                    bytes.push_back(CH_PERCENT);
                    bytes.push_back(legal_digit());
                    bytes.push_back(legal_digit());
                end
                else
                begin
                    b = 8'($urandom_range(0, 255));
                    while (b == CH_PERCENT)
                        b = 8'($urandom_range(0, 255));
                    bytes.push_back(b);
                end
            end
            if (kind >= 7)
            begin
                pos = $urandom_range(0, bytes.size() - 1);
                if ($urandom_range(0, 1) == 0)
                    bytes[pos] = odd_byte();
                else
                    while (bytes.size() > pos + 1)
                        void'(bytes.pop_back());
            end
        end
        else
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: bytes.push_back(CH_PERCENT);
                    3, 4, 5, 6: bytes.push_back(legal_digit());
                    default: bytes.push_back(odd_byte());
                endcase
            end
        end
        for (int i = 0; i < bytes.size(); i++)
        begin
            quiet = (decoded_items >= 700 && decoded_items < 1000);
            send_byte(bytes[i], i == bytes.size() - 1, 1'b0, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: out_byte %0h status %0d out_last %0d",
                           m_tdata, m_tuser, m_tlast);
                    failed = 1'b1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %0h, actual %0h",
                               want.out_byte, m_tdata);
                        failed = 1'b1;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_tuser);
                        failed = 1'b1;
                    end
                    if (m_tlast !== want.out_last)
                    begin
                        $error("out_last mismatch: expected %0d, actual %0d",
                               want.out_last, m_tlast);
                        failed = 1'b1;
                    end
                end
            end
            m_tready <= quiet || ($urandom_range(0, 99) >= 8);
        end
    end

    initial
    begin
        result_t typed_res;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            typed_res.out_byte = dir_rows[i].exp_byte;
            typed_res.status = status_t'(dir_rows[i].exp_status);
            typed_res.out_last = dir_rows[i].exp_last;
            send_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].has_res, typed_res);
        end
        decoded_items = 0;
        while (decoded_items < RANDOM_ITEMS)
            send_random_string();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (failed)
            $display("Simulation FAILED");
        else
            $display("Simulation PASSED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_decode.sv
hw/rtl/pcd_out_buf.sv
hw/rtl/percent_decoder_unit.sv
tb/percent_decoder_unit_tb.sv
